[hw/rtl/dmh_pkg.sv]
// Shared types, constants and codes for the d-ary max-heap priority queue.
package dmh_pkg;

    localparam int CAPACITY_DEF  = 1024;
    localparam int MAX_ARITY_DEF = 8;
    localparam int TAG_BITS      = 16;
    localparam int KEY_W         = 32;
    localparam int KIND_W        = 3;
    localparam int TAG_W         = 16;
    localparam int POS_W         = 11;
    localparam int COUNT_W       = 11;
    localparam int ARITY_W       = 4;
    localparam logic [ARITY_W-1:0] ARITY_RESET = 4'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND   = 3'd0,
        KIND_BUILD    = 3'd1,
        KIND_INSERT   = 3'd2,
        KIND_EXTRACT  = 3'd3,
        KIND_INCREASE = 3'd4,
        KIND_PEEK     = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
        logic [POS_W-1:0]        position;
    } req_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] out_key;
        logic [TAG_W-1:0]        out_tag;
        status_t                 status;
        logic [COUNT_W-1:0]      entry_count;
    } rsp_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_BITS-1:0]     tag;
    } entry_t;

    // Datapath operations, one per cycle
    typedef enum logic [4:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_SET_FULL,
        OP_SET_EMPTY,
        OP_SET_BADPOS,
        OP_APPEND,
        OP_RD_ROOT,
        OP_TAKE_ROOT,
        OP_TAKE_ROOT_RD_LAST,
        OP_TAKE_LAST,
        OP_RD_POS,
        OP_TAKE_POS,
        OP_DIV_UP,
        OP_DIV_BUILD,
        OP_RD_PARENT,
        OP_UP_MOVE,
        OP_WR_CUR,
        OP_DN_START,
        OP_RD_CAND,
        OP_DN_CMP,
        OP_DN_MOVE,
        OP_BLD_SET,
        OP_RD_BIDX,
        OP_TAKE_BIDX,
        OP_BLD_DEC,
        OP_LOAD_OUT
    } dp_op_t;

    typedef struct packed {
        kind_t kind;
        logic  count_zero;
        logic  count_full;
        logic  pos_bad;
        logic  p_is_root;
        logic  up_greater;
        logic  div_done;
        logic  cand_ok;
        logic  best_is_p;
        logic  bi_zero;
        logic  out_free;
    } dp_status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_PK_ROOT,
        S_EX_ROOT,
        S_EX_LAST,
        S_EX_CHK,
        S_INC_RD,
        S_UP_CHK,
        S_UP_DIV,
        S_UP_CMP,
        S_DN_START,
        S_DN_CHK,
        S_DN_CMP,
        S_DN_END,
        S_BLD_DIV,
        S_BLD_CHK,
        S_BLD_RD,
        S_FINISH
    } state_t;

endpackage

[hw/rtl/dmh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dmh_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/dmh_div.sv]
// Bit-serial restoring divider used for parent positions and the build start.
module dmh_div #(
    parameter int XW = 15,
    parameter int DW = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [XW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [XW-1:0] quotient
);

    localparam int CW = $clog2(XW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [XW-1:0] quo_reg, quo_next;
    logic [DW-1:0] dsr_reg, dsr_next;
    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;
    logic          fits;

    assign rem_sh = {rem_reg, quo_reg[XW-1]};
    assign fits   = rem_sh >= {1'b0, dsr_reg};
    assign diff   = rem_sh - {1'b0, dsr_reg};

    // One quotient bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(XW);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DW'(diff) : DW'(rem_sh);
            quo_next = {quo_reg[XW-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold working values
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[hw/rtl/dmh_datapath.sv]
// Heap datapath: entry store, working registers, parent divider and result register.
module dmh_datapath #(
    parameter int CAPACITY  = dmh_pkg::CAPACITY_DEF,
    parameter int MAX_ARITY = dmh_pkg::MAX_ARITY_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [dmh_pkg::ARITY_W-1:0]  cfg_wdata,
    input  dmh_pkg::req_t                req,
    input  logic                         rsp_ready,
    output logic                         rsp_valid,
    output dmh_pkg::rsp_t                rsp,
    input  dmh_pkg::dp_op_t              op,
    output dmh_pkg::dp_status_t          status
);

    import dmh_pkg::*;

    localparam int PW  = $clog2(CAPACITY + 1);
    localparam int AW  = $clog2(CAPACITY);
    localparam int DW  = $clog2(MAX_ARITY + 1);
    localparam int XW  = PW + DW;
    localparam int EW  = $bits(entry_t);
    localparam int AXW = (DW > ARITY_W) ? DW : ARITY_W;
    localparam int LW  = (XW > POS_W) ? XW : POS_W;

    logic [ARITY_W-1:0]  arity_reg, arity_next;
    logic [PW-1:0]       count_reg, count_next;
    logic                rsp_valid_reg, rsp_valid_next;
    req_t                item_reg, item_next;
    logic [PW-1:0]       p_reg, p_next;
    entry_t              cur_reg, cur_next;
    logic [XW-1:0]       cand_reg, cand_next;
    logic [DW-1:0]       i_reg, i_next;
    logic [PW-1:0]       best_pos_reg, best_pos_next;
    entry_t              best_reg, best_next;
    logic [PW-1:0]       bi_reg, bi_next;
    logic signed [KEY_W-1:0] res_key_reg, res_key_next;
    logic [TAG_W-1:0]    res_tag_reg, res_tag_next;
    status_t             res_st_reg, res_st_next;
    rsp_t                rsp_reg, rsp_next;

    logic [AXW-1:0]      arity_x;
    logic [AXW-1:0]      d_x;
    logic [DW-1:0]       d;
    logic                div_start;
    logic [XW-1:0]       dividend;
    logic                div_done;
    logic [XW-1:0]       q;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_raddr;
    logic [EW-1:0]       ram_wdata;
    logic [EW-1:0]       ram_rdata;
    entry_t              rd_entry;
    entry_t              item_entry;

    // Clamp the arity register to the supported range
    assign arity_x = AXW'(arity_reg);
    assign d_x     = (arity_x < AXW'(2)) ? AXW'(2)
                   : ((arity_x > AXW'(MAX_ARITY)) ? AXW'(MAX_ARITY) : arity_x);
    assign d       = DW'(d_x);

    assign rd_entry   = entry_t'(ram_rdata);
    assign item_entry = '{key: item_reg.key, tag: item_reg.tag[TAG_BITS-1:0]};

    // Parent divider: (p + d - 2) / d, or (count + d - 2) / d for build
    assign div_start = (op == OP_DIV_UP) || (op == OP_DIV_BUILD);
    assign dividend  = ((op == OP_DIV_UP) ? XW'(p_reg) : XW'(count_reg))
                     + XW'(d) - XW'(2);

    dmh_div #(
        .XW(XW),
        .DW(DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (d),
        .done     (div_done),
        .quotient (q)
    );

    dmh_ram #(
        .WIDTH(EW),
        .DEPTH(CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Select the read address
    always_comb
    begin
        case (op)
            OP_TAKE_ROOT_RD_LAST: ram_raddr = AW'(count_reg - PW'(1));
            OP_RD_POS:            ram_raddr = AW'(item_reg.position - POS_W'(1));
            OP_RD_PARENT:         ram_raddr = AW'(q - XW'(1));
            OP_RD_CAND:           ram_raddr = AW'(cand_reg - XW'(1));
            OP_RD_BIDX:           ram_raddr = AW'(bi_reg - PW'(1));
            default:              ram_raddr = '0;
        endcase
    end

    // Select the write
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = AW'(p_reg - PW'(1));
        ram_wdata = cur_reg;
        case (op)
            OP_APPEND:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(count_reg);
                ram_wdata = item_entry;
            end
            OP_UP_MOVE:
            begin
                ram_we    = 1'b1;
                ram_wdata = rd_entry;
            end
            OP_WR_CUR:
            begin
                ram_we = 1'b1;
            end
            OP_DN_MOVE:
            begin
                ram_we    = 1'b1;
                ram_wdata = best_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Next state of the working registers
    always_comb
    begin
        arity_next     = cfg_we ? cfg_wdata : arity_reg;
        count_next     = count_reg;
        item_next      = item_reg;
        p_next         = p_reg;
        cur_next       = cur_reg;
        cand_next      = cand_reg;
        i_next         = i_reg;
        best_pos_next  = best_pos_reg;
        best_next      = best_reg;
        bi_next        = bi_reg;
        res_key_next   = res_key_reg;
        res_tag_next   = res_tag_reg;
        res_st_next    = res_st_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (op)
            OP_ACCEPT:
            begin
                item_next    = req;
                res_key_next = '0;
                res_tag_next = '0;
                res_st_next  = ST_OK;
            end
            OP_SET_FULL:   res_st_next = ST_FULL;
            OP_SET_EMPTY:  res_st_next = ST_EMPTY;
            OP_SET_BADPOS: res_st_next = ST_BADPOS;
            OP_APPEND:
            begin
                count_next = count_reg + PW'(1);
                p_next     = count_reg + PW'(1);
                cur_next   = item_entry;
            end
            OP_TAKE_ROOT, OP_TAKE_ROOT_RD_LAST:
            begin
                res_key_next = rd_entry.key;
                res_tag_next = TAG_W'(rd_entry.tag);
            end
            OP_TAKE_LAST:
            begin
                cur_next   = rd_entry;
                count_next = count_reg - PW'(1);
                p_next     = PW'(1);
            end
            OP_TAKE_POS:
            begin
                cur_next.key = (item_reg.key > rd_entry.key) ? item_reg.key : rd_entry.key;
                cur_next.tag = rd_entry.tag;
                p_next       = PW'(item_reg.position);
            end
            OP_UP_MOVE:
            begin
                p_next = PW'(q);
            end
            OP_DN_START:
            begin
                cand_next     = XW'(d) * XW'(p_reg - PW'(1)) + XW'(2);
                i_next        = '0;
                best_pos_next = p_reg;
                best_next     = cur_reg;
            end
            OP_DN_CMP:
            begin
                if (rd_entry.key > best_reg.key)
                begin
                    best_pos_next = PW'(cand_reg);
                    best_next     = rd_entry;
                end
                cand_next = cand_reg + XW'(1);
                i_next    = i_reg + DW'(1);
            end
            OP_DN_MOVE:
            begin
                p_next = best_pos_reg;
            end
            OP_BLD_SET:
            begin
                bi_next = PW'(q);
            end
            OP_TAKE_BIDX:
            begin
                cur_next = rd_entry;
                p_next   = bi_reg;
            end
            OP_BLD_DEC:
            begin
                bi_next = bi_reg - PW'(1);
            end
            OP_LOAD_OUT:
            begin
                rsp_next = '{out_key: res_key_reg, out_tag: res_tag_reg,
                             status: res_st_reg, entry_count: COUNT_W'(count_reg)};
                rsp_valid_next = 1'b1;
            end
            default:
            begin
                rsp_next = rsp_reg;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arity_reg     <= ARITY_RESET;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            arity_reg     <= arity_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        p_reg        <= p_next;
        cur_reg      <= cur_next;
        cand_reg     <= cand_next;
        i_reg        <= i_next;
        best_pos_reg <= best_pos_next;
        best_reg     <= best_next;
        bi_reg       <= bi_next;
        res_key_reg  <= res_key_next;
        res_tag_reg  <= res_tag_next;
        res_st_reg   <= res_st_next;
        rsp_reg      <= rsp_next;
    end

    // Report to the controller
    assign status.kind       = kind_t'(item_reg.kind);
    assign status.count_zero = (count_reg == '0);
    assign status.count_full = (count_reg == PW'(CAPACITY));
    assign status.pos_bad    = (item_reg.position == '0)
                             || (LW'(item_reg.position) > LW'(count_reg));
    assign status.p_is_root  = (p_reg == PW'(1));
    assign status.up_greater = (cur_reg.key > rd_entry.key);
    assign status.div_done   = div_done;
    assign status.cand_ok    = (i_reg < d) && (cand_reg <= XW'(count_reg));
    assign status.best_is_p  = (best_pos_reg == p_reg);
    assign status.bi_zero    = (bi_reg == '0);
    assign status.out_free   = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[hw/rtl/dmh_ctrl.sv]
// Heap controller: sequences each operation as datapath commands.
module dmh_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  dmh_pkg::dp_status_t status,
    output dmh_pkg::dp_op_t     op
);

    import dmh_pkg::*;

    state_t state_reg, state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

    // Advance the sequence and issue commands
    always_comb
    begin
        state_next = state_reg;
        op         = OP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op         = OP_ACCEPT;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (status.kind)
                    KIND_APPEND, KIND_INSERT:
                    begin
                        if (status.count_full)
                        begin
                            op         = OP_SET_FULL;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            op         = OP_APPEND;
                            state_next = (status.kind == KIND_INSERT) ? S_UP_CHK : S_FINISH;
                        end
                    end
                    KIND_BUILD:
                    begin
                        op         = OP_DIV_BUILD;
                        state_next = S_BLD_DIV;
                    end
                    KIND_EXTRACT, KIND_PEEK:
                    begin
                        if (status.count_zero)
                        begin
                            op         = OP_SET_EMPTY;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            op         = OP_RD_ROOT;
                            state_next = (status.kind == KIND_PEEK) ? S_PK_ROOT : S_EX_ROOT;
                        end
                    end
                    KIND_INCREASE:
                    begin
                        if (status.pos_bad)
                        begin
                            op         = OP_SET_BADPOS;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            op         = OP_RD_POS;
                            state_next = S_INC_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_PK_ROOT:
            begin
                op         = OP_TAKE_ROOT;
                state_next = S_FINISH;
            end
            S_EX_ROOT:
            begin
                op         = OP_TAKE_ROOT_RD_LAST;
                state_next = S_EX_LAST;
            end
            S_EX_LAST:
            begin
                op         = OP_TAKE_LAST;
                state_next = S_EX_CHK;
            end
            S_EX_CHK:
            begin
                if (status.count_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    op         = OP_DN_START;
                    state_next = S_DN_CHK;
                end
            end
            S_INC_RD:
            begin
                op         = OP_TAKE_POS;
                state_next = S_UP_CHK;
            end
            S_UP_CHK:
            begin
                if (status.p_is_root)
                begin
                    op         = OP_WR_CUR;
                    state_next = S_FINISH;
                end
                else
                begin
                    op         = OP_DIV_UP;
                    state_next = S_UP_DIV;
                end
            end
            S_UP_DIV:
            begin
                if (status.div_done)
                begin
                    op         = OP_RD_PARENT;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (status.up_greater)
                begin
                    op         = OP_UP_MOVE;
                    state_next = S_UP_CHK;
                end
                else
                begin
                    op         = OP_WR_CUR;
                    state_next = S_FINISH;
                end
            end
            S_DN_START:
            begin
                op         = OP_DN_START;
                state_next = S_DN_CHK;
            end
            S_DN_CHK:
            begin
                if (status.cand_ok)
                begin
                    op         = OP_RD_CAND;
                    state_next = S_DN_CMP;
                end
                else if (status.best_is_p)
                begin
                    op         = OP_WR_CUR;
                    state_next = S_DN_END;
                end
                else
                begin
                    op         = OP_DN_MOVE;
                    state_next = S_DN_START;
                end
            end
            S_DN_CMP:
            begin
                op         = OP_DN_CMP;
                state_next = S_DN_CHK;
            end
            S_DN_END:
            begin
                if (status.kind == KIND_BUILD)
                begin
                    op         = OP_BLD_DEC;
                    state_next = S_BLD_CHK;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_BLD_DIV:
            begin
                if (status.div_done)
                begin
                    op         = OP_BLD_SET;
                    state_next = S_BLD_CHK;
                end
            end
            S_BLD_CHK:
            begin
                if (status.bi_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    op         = OP_RD_BIDX;
                    state_next = S_BLD_RD;
                end
            end
            S_BLD_RD:
            begin
                op         = OP_TAKE_BIDX;
                state_next = S_DN_START;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    op         = OP_LOAD_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/dary_max_heap_priority_queue.sv]
// Top level of the d-ary max-heap priority queue: controller, datapath and checks.
// Works on one word at a time; the next request word is taken once the previous
// result sits in the output register, which frees the input while the result waits.
// Extract walks down one level at a time, insert and increase-key walk up one level
// at a time, each level waiting on the bit-serial parent divider, and build costs
// one sift-down per inner node. Every step is bound by the single read port of
// the entry store, whose read data is registered. The store needs no clearing
// after reset; entries past the count are never read.
module dary_max_heap_priority_queue #(
    parameter int CAPACITY  = dmh_pkg::CAPACITY_DEF,
    parameter int MAX_ARITY = dmh_pkg::MAX_ARITY_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [dmh_pkg::ARITY_W-1:0] cfg_wdata,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  dmh_pkg::req_t               req,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output dmh_pkg::rsp_t               rsp
);

    import dmh_pkg::*;

    dp_op_t     op;
    dp_status_t status;

    dmh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .op        (op)
    );

    dmh_datapath #(
        .CAPACITY  (CAPACITY),
        .MAX_ARITY (MAX_ARITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .op        (op),
        .status    (status)
    );

`ifndef SYNTH
    // Drop ready after taking a word
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while a word is in progress");

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_LOAD_OUT |-> (!rsp_valid || rsp_ready))
        else $error("pending result overwritten");

    // Failed operations return no key or tag
    a_quiet_fail: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.out_key == '0 && rsp.out_tag == '0)
        else $error("failed operation returned data");
`endif

endmodule

[tb/dary_max_heap_priority_queue_checker.sv]
// Checker for the d-ary max-heap queue: watches both channels, predicts and compares.
module dary_max_heap_priority_queue_checker
    import dmh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [ARITY_W-1:0]   cfg_wdata,
    input  logic                 req_valid,
    input  logic                 req_ready,
    input  req_t                 req,
    input  logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  rsp_t                 rsp,
    output int                   fail_count,
    output int                   pending
);

    localparam int CAP = CAPACITY_DEF;

    logic signed [KEY_W-1:0] heap_key [CAP];
    logic [TAG_W-1:0]        heap_tag [CAP];
    int                      heap_count;
    logic [ARITY_W-1:0]      arity_reg;
    rsp_t                    expected_rsp [$];

    assign pending = expected_rsp.size();

    // Count and print one mismatch
    task automatic report(input string what);
        fail_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic int fan_out();
        if (arity_reg < 2)
            return 2;
        if (arity_reg > MAX_ARITY_DEF)
            return MAX_ARITY_DEF;
        return arity_reg;
    endfunction

    task automatic swap_entries(input int a, input int b);
        logic signed [KEY_W-1:0] k;
        logic [TAG_W-1:0]        t;
        k = heap_key[a-1]; t = heap_tag[a-1];
        heap_key[a-1] = heap_key[b-1]; heap_tag[a-1] = heap_tag[b-1];
        heap_key[b-1] = k; heap_tag[b-1] = t;
    endtask

    task automatic sink(input int p, input int d);
        int best;
        int c;
        forever
        begin
            best = p;
            for (int i = 0; i < d; i++)
            begin
                c = d * (p - 1) + 2 + i;
                if (c <= heap_count && heap_key[c-1] > heap_key[best-1])
                    best = c;
            end
            if (best == p)
                return;
            swap_entries(p, best);
            p = best;
        end
    endtask

    task automatic rise(input int p, input int d);
        int q;
        while (p > 1)
        begin
            q = (p + d - 2) / d;
            if (heap_key[p-1] <= heap_key[q-1])
                return;
            swap_entries(p, q);
            p = q;
        end
    endtask

    // Apply one request word to the heap copy and return the expected result
    task automatic apply_request(input req_t r, output rsp_t res);
        int d;
        d = fan_out();
        res = '0;
        res.status = ST_OK;
        case (r.kind)
            KIND_APPEND, KIND_INSERT:
                if (heap_count >= CAP)
                    res.status = ST_FULL;
                else
                begin
                    heap_key[heap_count] = r.key;
                    heap_tag[heap_count] = r.tag;
                    heap_count++;
                    if (r.kind == KIND_INSERT)
                        rise(heap_count, d);
                end
            KIND_BUILD:
                for (int i = (heap_count + d - 2) / d; i >= 1; i--)
                    sink(i, d);
            KIND_EXTRACT:
                if (heap_count == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.out_key = heap_key[0];
                    res.out_tag = heap_tag[0];
                    heap_key[0] = heap_key[heap_count-1];
                    heap_tag[0] = heap_tag[heap_count-1];
                    heap_count--;
                    if (heap_count > 0)
                        sink(1, d);
                end
            KIND_INCREASE:
                if (r.position == 0 || r.position > heap_count)
                    res.status = ST_BADPOS;
                else
                begin
                    if (r.key > heap_key[r.position-1])
                        heap_key[r.position-1] = r.key;
                    rise(r.position, d);
                end
            KIND_PEEK:
                if (heap_count == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.out_key = heap_key[0];
                    res.out_tag = heap_tag[0];
                end
            default:
                ;
        endcase
        res.entry_count = heap_count[COUNT_W-1:0];
    endtask

    // Track configuration, predict on accepted requests, compare accepted results
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        rsp_t fresh;
        if (!rst_n)
        begin
            heap_count = 0;
            arity_reg  = ARITY_RESET;
            fail_count = 0;
            expected_rsp.delete();
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp.size() == 0)
                    report("result word with nothing expected");
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.out_key !== want.out_key)
                        report($sformatf("out_key %0d, want %0d", rsp.out_key, want.out_key));
                    if (rsp.out_tag !== want.out_tag)
                        report($sformatf("out_tag %0h, want %0h", rsp.out_tag, want.out_tag));
                    if (rsp.status !== want.status)
                        report($sformatf("status %0d, want %0d", rsp.status, want.status));
                    if (rsp.entry_count !== want.entry_count)
                        report($sformatf("entry_count %0d, want %0d",
                                         rsp.entry_count, want.entry_count));
                end
            end
            if (req_valid && req_ready)
            begin
                apply_request(req, fresh);
                expected_rsp.insert(expected_rsp.size(), fresh);
            end
            if (cfg_we)
                arity_reg = cfg_wdata;
        end
    end

    // Flag any expectation left over at the end
    task automatic flush_check();
        while (expected_rsp.size() > 0)
        begin
            void'(expected_rsp.pop_front());
            report("expected result word never arrived");
        end
    endtask

endmodule

[tb/tb_dary_max_heap_priority_queue.sv]
// Testbench top for the d-ary max-heap queue: stimulus, idling and the verdict.
module tb_dary_max_heap_priority_queue;
    import dmh_pkg::*;

    localparam int STALL_LIMIT = 400000;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [ARITY_W-1:0] cfg_wdata;
    logic               req_valid;
    logic               req_ready;
    req_t               req;
    logic               rsp_valid;
    logic               rsp_ready;
    rsp_t               rsp;
    int                 fail_count;
    int                 pending;
    int                 model_count;
    int                 idle_cycles;
    bit                 calm;

    dary_max_heap_priority_queue DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    dary_max_heap_priority_queue_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: random stall bursts, none once calm
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            rsp_ready <= 1'b1;
        end
    end

    // Watchdog: cycles with no accepted word
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("dary_max_heap_priority_queue regression: fail");
            $finish;
        end
    end

    // Send one request word and hold it until accepted
    task automatic send_word(input kind_t k, input logic signed [KEY_W-1:0] key,
                             input logic [TAG_W-1:0] tag, input logic [POS_W-1:0] pos);
        if (!calm && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 7)) @(negedge clk);
        req.kind     <= k;
        req.key      <= key;
        req.tag      <= tag;
        req.position <= pos;
        req_valid    <= 1'b1;
        // Ready only moves at the rising edge; high here means the word goes next edge
        while (!req_ready)
            @(negedge clk);
        @(negedge clk);
        req_valid <= 1'b0;
        @(negedge clk);
        case (k)
            KIND_APPEND, KIND_INSERT: if (model_count < 1024) model_count++;
            KIND_EXTRACT: if (model_count > 0) model_count--;
            default: ;
        endcase
    endtask

    // Raw word including the unused kinds
    task automatic send_raw(input logic [KIND_W-1:0] k);
        req.kind     <= kind_t'(k);
        req.key      <= $urandom;
        req.tag      <= TAG_W'($urandom);
        req.position <= POS_W'($urandom);
        req_valid    <= 1'b1;
        while (!req_ready)
            @(negedge clk);
        @(negedge clk);
        req_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Drain, let the block settle, then write the arity
    task automatic set_arity(input logic [ARITY_W-1:0] value);
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic signed [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 9)) - 5;
            default: return $urandom;
        endcase
    endfunction

    // One random word, weighted toward well-formed heap traffic
    task automatic random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            send_word(KIND_INSERT, rand_key(), TAG_W'($urandom), 0);
        else if (pick < 50)
            send_word(KIND_APPEND, rand_key(), TAG_W'($urandom), 0);
        else if (pick < 72)
            send_word(KIND_EXTRACT, $urandom, TAG_W'($urandom), POS_W'($urandom));
        else if (pick < 84)
            send_word(KIND_INCREASE, rand_key(), TAG_W'($urandom),
                      (model_count > 0 && $urandom_range(0, 5) != 0)
                      ? POS_W'($urandom_range(1, model_count)) : POS_W'($urandom));
        else if (pick < 92)
            send_word(KIND_PEEK, $urandom, TAG_W'($urandom), POS_W'($urandom));
        else if (pick < 97)
            send_word(KIND_BUILD, $urandom, TAG_W'($urandom), POS_W'($urandom));
        else
            send_raw(KIND_W'($urandom_range(6, 7)));
    endtask

    initial
    begin
        logic [ARITY_W-1:0] arities [6];
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        req_valid   = 1'b0;
        req         = '0;
        idle_cycles = 0;
        model_count = 0;
        calm        = 1'b0;
        arities     = '{4'd0, 4'd15, 4'd3, 4'd8, 4'd5, 4'd2};
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty-heap corner cases, extremes, every kind
        send_word(KIND_EXTRACT, 0, 0, 0);
        send_word(KIND_PEEK, 0, 0, 0);
        send_word(KIND_INCREASE, 5, 0, 0);
        send_word(KIND_INCREASE, 5, 0, 11'h7ff);
        send_word(KIND_BUILD, 0, 0, 0);
        send_raw(3'd6);
        send_raw(3'd7);
        send_word(KIND_APPEND, 32'sh80000000, 16'h0000, 0);
        send_word(KIND_APPEND, 32'sh7fffffff, 16'hffff, 11'h7ff);
        send_word(KIND_APPEND, 7, 16'h5555, 0);
        send_word(KIND_APPEND, 7, 16'haaaa, 0);
        send_word(KIND_BUILD, 0, 0, 0);
        send_word(KIND_INSERT, -1, 16'h1234, 0);
        send_word(KIND_INCREASE, 32'sh7fffffff, 0, 11'd5);
        send_word(KIND_INCREASE, 32'sh80000000, 0, 11'd2);
        send_word(KIND_INCREASE, 0, 0, 11'd6);
        send_word(KIND_PEEK, 0, 0, 0);
        send_word(KIND_EXTRACT, 0, 0, 0);
        send_word(KIND_EXTRACT, 0, 0, 0);

        // Random phases across arities, extremes included
        foreach (arities[a])
        begin
            set_arity(arities[a]);
            repeat (80) random_word();
            if (a == 2)
            begin
                // Hold the sender until all results are back
                while (pending != 0)
                    @(negedge clk);
            end
        end

        // Rebuild the grown heap, probe the top position, then drain part of it
        set_arity(4'd4);
        send_word(KIND_BUILD, 0, 0, 0);
        send_word(KIND_INCREASE, 32'sh7fffffff, 16'h1, 11'd1024);
        repeat (20) send_word(KIND_EXTRACT, 0, 0, 0);
        set_arity(4'd1);
        repeat (60) random_word();

        // Last stretch without idling
        calm = 1'b1;
        repeat (80) random_word();

        while (pending != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        checker_i.flush_check();
        if (fail_count == 0)
            $display("dary_max_heap_priority_queue regression: pass");
        else
            $display("dary_max_heap_priority_queue regression: fail");
        $finish;
    end

endmodule
